// ----- sv/qrv1l_pkg.sv -----
// Package: shared types, codes and field arithmetic for the QR 1-L codeword encoder.
`default_nettype none

package qrv1l_pkg;

    localparam int CHECK_CODEWORDS = 7;

    localparam logic [7:0] FIELD_REDUCE = 8'h1D;
    localparam logic [3:0] MODE_BYTE    = 4'b0100;
    localparam logic [7:0] PAD_A        = 8'hEC;
    localparam logic [7:0] PAD_B        = 8'h11;

    // Generator coefficients alpha^87, ^229, ^146, ^149, ^238, ^102, ^21
    localparam logic [7:0] GEN_COEF [CHECK_CODEWORDS] =
        '{8'd127, 8'd122, 8'd154, 8'd164, 8'd11, 8'd68, 8'd117};

    typedef enum logic
    {
        CMD_BEGIN = 1'b0,
        CMD_DATA  = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        STATUS_OK       = 2'd0,
        STATUS_TOO_LONG = 2'd1,
        STATUS_NO_MSG   = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_TERM,
        ST_PAD,
        ST_CHECK
    } state_t;

    typedef struct packed
    {
        logic [0:0] command;
        logic [7:0] value;
    } in_item_t;

    typedef struct packed
    {
        logic [7:0] codeword;
        logic [4:0] codeword_index;
        logic       is_last;
        logic [1:0] status;
    } out_item_t;

    // GF(256) product, field polynomial 0x11D
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = '0;
        x   = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_REDUCE : 8'h00);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ----- sv/qr_v1l_codeword_encoder.sv -----
// Top level: QR version 1-L byte-mode codeword stream with Reed-Solomon check bytes.
//
// The block turns a byte-mode message into the codeword block of a QR version 1-L
// symbol. A begin transaction (command 0) carries the message length and emits the
// first codeword, mode 0100 followed by the high nibble of the length. Each data
// transaction (command 1) emits one codeword built from the held low nibble and the
// high nibble of the new byte. The transaction that completes the message is
// followed without further input by the terminator codeword, alternating 0xEC/0x11
// pads up to DATA_CODEWORDS data codewords, and seven check bytes, the last flagged
// with is_last. Every data codeword enters a row of seven remainder cells as it is
// emitted; during the check phase the row shifts out with zero feedback. A begin
// longer than DATA_CODEWORDS-2 gives a single result with status 1 and drops any
// open message; a data byte with no open message gives a single result with status
// 2. A begin while a message is open drops it silently. The block emits one codeword
// per cycle through a single output register while the output is not stalled, and
// the transaction that ends a message holds the input side stalled while the tail
// is produced; a stall on the output side holds both the input and the tail.
`default_nettype none

module qr_v1l_codeword_encoder #(
    parameter int DATA_CODEWORDS = 19
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire qrv1l_pkg::in_item_t  cmd_item,
    output logic                      cw_valid,
    input  wire logic                 cw_stall,
    output qrv1l_pkg::out_item_t      cw_item
);

    localparam int          NCHK     = qrv1l_pkg::CHECK_CODEWORDS;
    localparam logic [7:0]  MAX_LEN  = 8'(DATA_CODEWORDS - 2);
    localparam logic [5:0]  DATA_END = 6'(DATA_CODEWORDS);
    localparam logic [4:0]  LAST_IDX = 5'(DATA_CODEWORDS + NCHK - 1);

    qrv1l_pkg::state_t    state_reg, state_next;
    logic                 open_reg, open_next;
    logic [4:0]           exp_reg, exp_next;
    logic [4:0]           seen_reg, seen_next;
    logic [4:0]           sent_reg, sent_next;
    logic [3:0]           held_reg, held_next;
    logic                 pad_first_reg, pad_first_next;
    logic                 cw_valid_reg;
    qrv1l_pkg::out_item_t cw_item_reg;

    // Remainder chain: chain[i] is cell i, chain[NCHK] is the zero fed into the tail.
    logic [7:0]           chain [NCHK+1];
    logic                 rs_step;
    logic                 rs_clear;
    logic [7:0]           rs_factor;

    logic                 out_free;
    logic                 accept;
    logic                 load_out;
    qrv1l_pkg::out_item_t res;
    logic [7:0]           cw;
    logic [5:0]           sent_inc;
    logic [5:0]           seen_inc;

    assign out_free  = !cw_valid_reg || !cw_stall;
    assign cmd_stall = !((state_reg == qrv1l_pkg::ST_IDLE) && out_free);
    assign accept    = cmd_valid && !cmd_stall;
    assign sent_inc  = {1'b0, sent_reg} + 6'd1;
    assign seen_inc  = {1'b0, seen_reg} + 6'd1;

    // ------------------------------------------------------------------
    // Row of remainder cells, each handing its byte to the next one down
    // ------------------------------------------------------------------
    assign chain[NCHK] = 8'h00;

    for (genvar g = 0; g < NCHK; g++)
    begin : g_cell
        qrv1l_rs_cell #(
            .COEF (qrv1l_pkg::GEN_COEF[g])
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (rs_step),
            .clear     (rs_clear),
            .factor    (rs_factor),
            .neighbor  (chain[g+1]),
            .remainder (chain[g])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer: next state, codeword selection and remainder control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        exp_next       = exp_reg;
        seen_next      = seen_reg;
        sent_next      = sent_reg;
        held_next      = held_reg;
        pad_first_next = pad_first_reg;
        rs_step        = 1'b0;
        rs_clear       = 1'b0;
        rs_factor      = 8'h00;
        load_out       = 1'b0;
        cw             = 8'h00;
        res            = '{codeword: 8'h00, codeword_index: 5'd0, is_last: 1'b0,
                           status: qrv1l_pkg::STATUS_OK};

        unique case (state_reg)
            qrv1l_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    if (cmd_item.command == qrv1l_pkg::CMD_BEGIN)
                    begin
                        if (cmd_item.value > MAX_LEN)
                        begin
                            // Drop any open message and flag the bad length.
                            open_next   = 1'b0;
                            res.is_last = 1'b1;
                            res.status  = qrv1l_pkg::STATUS_TOO_LONG;
                        end
                        else
                        begin
                            cw        = {qrv1l_pkg::MODE_BYTE, cmd_item.value[7:4]};
                            open_next = 1'b1;
                            exp_next  = cmd_item.value[4:0];
                            seen_next = 5'd0;
                            sent_next = 5'd1;
                            held_next = cmd_item.value[3:0];
                            rs_clear  = 1'b1;
                            rs_step   = 1'b1;
                            rs_factor = cw;
                            res.codeword = cw;
                            if (cmd_item.value == 8'd0)
                            begin
                                state_next = qrv1l_pkg::ST_TERM;
                            end
                        end
                    end
                    else if (!open_reg)
                    begin
                        res.is_last = 1'b1;
                        res.status  = qrv1l_pkg::STATUS_NO_MSG;
                    end
                    else
                    begin
                        cw        = {held_reg, cmd_item.value[7:4]};
                        held_next = cmd_item.value[3:0];
                        seen_next = seen_inc[4:0];
                        sent_next = sent_inc[4:0];
                        rs_step   = 1'b1;
                        rs_factor = cw ^ chain[0];
                        res.codeword       = cw;
                        res.codeword_index = sent_reg;
                        if (seen_inc >= {1'b0, exp_reg})
                        begin
                            state_next = qrv1l_pkg::ST_TERM;
                        end
                    end
                end
            end

            qrv1l_pkg::ST_TERM:
            begin
                if (out_free)
                begin
                    cw             = {held_reg, 4'h0};
                    load_out       = 1'b1;
                    rs_step        = 1'b1;
                    rs_factor      = cw ^ chain[0];
                    sent_next      = sent_inc[4:0];
                    pad_first_next = 1'b1;
                    res.codeword       = cw;
                    res.codeword_index = sent_reg;
                    state_next = (sent_inc < DATA_END) ? qrv1l_pkg::ST_PAD
                                                       : qrv1l_pkg::ST_CHECK;
                end
            end

            qrv1l_pkg::ST_PAD:
            begin
                if (out_free)
                begin
                    cw             = pad_first_reg ? qrv1l_pkg::PAD_A : qrv1l_pkg::PAD_B;
                    load_out       = 1'b1;
                    rs_step        = 1'b1;
                    rs_factor      = cw ^ chain[0];
                    sent_next      = sent_inc[4:0];
                    pad_first_next = !pad_first_reg;
                    res.codeword       = cw;
                    res.codeword_index = sent_reg;
                    if (sent_inc >= DATA_END)
                    begin
                        state_next = qrv1l_pkg::ST_CHECK;
                    end
                end
            end

            qrv1l_pkg::ST_CHECK:
            begin
                if (out_free)
                begin
                    // Shift the check bytes out with zero feedback.
                    load_out  = 1'b1;
                    rs_step   = 1'b1;
                    sent_next = sent_inc[4:0];
                    res.codeword       = chain[0];
                    res.codeword_index = sent_reg;
                    res.is_last        = (sent_reg == LAST_IDX);
                    if (sent_reg == LAST_IDX)
                    begin
                        open_next  = 1'b0;
                        state_next = qrv1l_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = qrv1l_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qrv1l_pkg::ST_IDLE;
            open_reg      <= 1'b0;
            exp_reg       <= '0;
            seen_reg      <= '0;
            sent_reg      <= '0;
            held_reg      <= '0;
            pad_first_reg <= 1'b1;
            cw_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            exp_reg       <= exp_next;
            seen_reg      <= seen_next;
            sent_reg      <= sent_next;
            held_reg      <= held_next;
            pad_first_reg <= pad_first_next;
            if (load_out)
            begin
                cw_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                cw_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload: load a new transaction only when the register is free.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            cw_item_reg <= res;
        end
    end

    assign cw_valid = cw_valid_reg;
    assign cw_item  = cw_item_reg;

endmodule

`default_nettype wire

// ----- sv/qrv1l_rs_cell.sv -----
// One Reed-Solomon remainder cell: holds one check byte of the division chain.
`default_nettype none

module qrv1l_rs_cell #(
    parameter logic [7:0] COEF = 8'd1
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic       clear,
    input  wire logic [7:0] factor,
    input  wire logic [7:0] neighbor,
    output logic [7:0]      remainder
);

    logic [7:0] rem_reg;
    logic [7:0] rem_next;

    // Take the neighbor's byte (or zero on a fresh message) and add this tap's share.
    always_comb
    begin
        rem_next = (clear ? 8'h00 : neighbor) ^ qrv1l_pkg::gf_mul(COEF, factor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
        end
    end

    assign remainder = rem_reg;

endmodule

`default_nettype wire
